/* sv/gsb_pkg.sv */
`default_nettype none

package gsb_pkg;

  // Branch addresses, targets and table indexes all use this width.
  localparam int ADDR_BITS    = 10;
  localparam int HISTORY_BITS = 8;
  localparam int TABLE_DEPTH  = 1 << ADDR_BITS;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_PREDICT = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INSTALL = 2'd2;

  localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;
  localparam logic [1:0] CTR_MAX        = 2'd3;
  localparam logic [1:0] CTR_MIN        = 2'd0;

  typedef struct packed {
    logic       valid;
    logic [1:0] value;
  } ctr_entry_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] target;
  } tgt_entry_t;

endpackage

`default_nettype wire

/* sv/gshare_predictor_with_btb.sv */
`default_nettype none

// Gshare branch predictor with a branch target buffer.
//
// Command channel: an operation word is taken at a rising edge where start
// is high and busy is low. in_operation selects predict, update (trains the
// counter with in_outcome_taken and shifts it into the global history) or
// install (writes in_target_address for in_branch_address).
// Result channel: every accepted word yields exactly one result word, shown
// for a single cycle with out_valid high. The receiver cannot stall, so the
// result must be captured in that cycle. Update and install return zeros.
// The result word is registered at the edge that follows acceptance. Both
// tables are synchronous RAMs with a registered read; the tables are read at
// acceptance, then the word is modified and written back, and busy holds off
// the next word for that write-back cycle, so a new word is never taken
// before the last one is through.
// Reset: the history register clears, then a clearing pass writes every
// entry of both tables as invalid, one entry per cycle, over all 1024
// entries (the table depth). busy stays high for the whole pass.

module gshare_predictor_with_btb (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  wire  [gsb_pkg::OP_W-1:0]       in_operation,
  input  wire  [gsb_pkg::ADDR_BITS-1:0]  in_branch_address,
  input  wire                            in_outcome_taken,
  input  wire  [gsb_pkg::ADDR_BITS-1:0]  in_target_address,
  output logic                           out_valid,
  output logic                           out_buffer_hit,
  output logic                           out_predict_taken,
  output logic [gsb_pkg::ADDR_BITS-1:0]  out_predicted_target
);
  import gsb_pkg::*;

  // Width wide enough to fold the history onto the address before masking.
  localparam int XOR_W = (HISTORY_BITS > ADDR_BITS) ? HISTORY_BITS : ADDR_BITS;

  // Table storage. Each entry carries its own valid bit; the clearing pass
  // after reset is what makes every entry start out invalid.
  ctr_entry_t ctr_mem [TABLE_DEPTH];
  tgt_entry_t tgt_mem [TABLE_DEPTH];

  // Clearing pass state.
  logic                 clr_active_r, clr_active_nxt;
  logic [ADDR_BITS-1:0] clr_idx_r, clr_idx_nxt;

  // Global history.
  logic [HISTORY_BITS-1:0] hist_r, hist_nxt;

  // The word in flight while the tables are read.
  logic                 pend_r, pend_nxt;
  logic [OP_W-1:0]      st_op_r;
  logic [ADDR_BITS-1:0] st_ctr_idx_r;
  logic [ADDR_BITS-1:0] st_addr_r;
  logic                 st_taken_r;
  logic [ADDR_BITS-1:0] st_target_r;

  // Registered read data from the tables.
  ctr_entry_t ctr_rd_r;
  tgt_entry_t tgt_rd_r;

  // Result registers.
  logic                 res_valid_r, res_valid_nxt;
  logic                 res_hit_r, res_hit_nxt;
  logic                 res_taken_r, res_taken_nxt;
  logic [ADDR_BITS-1:0] res_target_r, res_target_nxt;

  // Write ports.
  logic                 ctr_we, tgt_we;
  logic [ADDR_BITS-1:0] ctr_wa, tgt_wa;
  ctr_entry_t           ctr_wd;
  tgt_entry_t           tgt_wd;

  logic                 accept;
  logic [XOR_W-1:0]     hash;
  logic [ADDR_BITS-1:0] rd_ctr_idx;
  logic [1:0]           ctr_cur, ctr_step;

  assign busy   = clr_active_r | pend_r;
  assign accept = start & ~busy;

  // Gshare index: history XOR branch address, masked to the table width.
  assign hash       = XOR_W'(hist_r) ^ XOR_W'(in_branch_address);
  assign rd_ctr_idx = hash[ADDR_BITS-1:0];

  // Saturating counter step for the update operation; an unseen counter
  // starts from zero.
  always_comb begin
    ctr_cur = ctr_rd_r.valid ? ctr_rd_r.value : CTR_MIN;
    if (st_taken_r) begin
      ctr_step = (ctr_cur == CTR_MAX) ? ctr_cur : ctr_cur + 2'd1;
    end else begin
      ctr_step = (ctr_cur == CTR_MIN) ? ctr_cur : ctr_cur - 2'd1;
    end
  end

  // Modify and write-back stage, plus the clearing pass, which owns the
  // write ports whenever it runs.
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_idx_nxt    = clr_idx_r;
    hist_nxt       = hist_r;
    pend_nxt       = accept;
    res_valid_nxt  = 1'b0;
    res_hit_nxt    = 1'b0;
    res_taken_nxt  = 1'b0;
    res_target_nxt = '0;
    ctr_we         = 1'b0;
    ctr_wa         = st_ctr_idx_r;
    ctr_wd         = '0;
    tgt_we         = 1'b0;
    tgt_wa         = st_addr_r;
    tgt_wd         = '0;

    if (clr_active_r) begin
      ctr_we      = 1'b1;
      ctr_wa      = clr_idx_r;
      tgt_we      = 1'b1;
      tgt_wa      = clr_idx_r;
      clr_idx_nxt = clr_idx_r + ADDR_BITS'(1);
      if (clr_idx_r == {ADDR_BITS{1'b1}}) begin
        clr_active_nxt = 1'b0;
      end
    end else if (pend_r) begin
      res_valid_nxt = 1'b1;
      unique case (st_op_r)
        OP_PREDICT: begin
          if (tgt_rd_r.valid) begin
            res_hit_nxt    = 1'b1;
            res_target_nxt = tgt_rd_r.target;
            if (!ctr_rd_r.valid) begin
              // First sight of this counter: make it weakly taken.
              ctr_we        = 1'b1;
              ctr_wd.valid  = 1'b1;
              ctr_wd.value  = CTR_WEAK_TAKEN;
              res_taken_nxt = 1'b1;
            end else begin
              res_taken_nxt = ctr_rd_r.value[1];
            end
          end
        end
        OP_UPDATE: begin
          ctr_we       = 1'b1;
          ctr_wd.valid = 1'b1;
          ctr_wd.value = ctr_step;
          hist_nxt     = HISTORY_BITS'({hist_r, st_taken_r});
        end
        OP_INSTALL: begin
          tgt_we        = 1'b1;
          tgt_wd.valid  = 1'b1;
          tgt_wd.target = st_target_r;
        end
        default: begin
          // Unused code: no state change, zero result.
        end
      endcase
    end
  end

  // Tables: one write port and one registered read port each. Reads are
  // issued only at acceptance and writes only in the following cycle or
  // during the clearing pass, so the two never touch the same edge.
  always_ff @(posedge clk) begin
    if (ctr_we) begin
      ctr_mem[ctr_wa] <= ctr_wd;
    end
    if (accept) begin
      ctr_rd_r <= ctr_mem[rd_ctr_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[tgt_wa] <= tgt_wd;
    end
    if (accept) begin
      tgt_rd_r <= tgt_mem[in_branch_address];
    end
  end

  // Captured command word.
  always_ff @(posedge clk) begin
    if (accept) begin
      st_op_r      <= in_operation;
      st_ctr_idx_r <= rd_ctr_idx;
      st_addr_r    <= in_branch_address;
      st_taken_r   <= in_outcome_taken;
      st_target_r  <= in_target_address;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      hist_r       <= '0;
      pend_r       <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_idx_r    <= clr_idx_nxt;
      hist_r       <= hist_nxt;
      pend_r       <= pend_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    res_hit_r    <= res_hit_nxt;
    res_taken_r  <= res_taken_nxt;
    res_target_r <= res_target_nxt;
  end

  assign out_valid            = res_valid_r;
  assign out_buffer_hit       = res_hit_r;
  assign out_predict_taken    = res_taken_r;
  assign out_predicted_target = res_target_r;

endmodule

`default_nettype wire

/* sv/gsb_checker.sv */
`default_nettype none

module gsb_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            start,
  input wire                            busy,
  input wire [gsb_pkg::OP_W-1:0]        in_operation,
  input wire                            out_valid,
  input wire                            out_buffer_hit,
  input wire                            out_predict_taken,
  input wire [gsb_pkg::ADDR_BITS-1:0]   out_predicted_target
);
  import gsb_pkg::*;

  // Every accepted word produces its result word.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted word produced no result");

  // No result word without an accepted word before it.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result word without an accepted command");

  // A taken guess or a target only comes with a buffer hit.
  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_buffer_hit) |-> (!out_predict_taken && out_predicted_target == '0))
    else $error("miss result carries a prediction");

  // Non-predict words return an all-zero result.
  a_non_predict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation != OP_PREDICT) |-> ##2 !out_buffer_hit)
    else $error("non-predict word reported a hit");

  // The table clearing pass holds off commands right after reset.
  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("block not busy after reset");

endmodule

bind gshare_predictor_with_btb gsb_checker u_gsb_checker (.*);

`default_nettype wire

/* dv/tb_gshare_predictor_with_btb.sv */
// One expected result word for the gshare predictor.
typedef struct packed {
  logic                          hit;
  logic                          taken;
  logic [gsb_pkg::ADDR_BITS-1:0] target;
} branch_outlook_t;

// Shadow copy of the predictor tables. Each accepted command word is applied
// to the copy as it is accepted, and the result word it must produce is queued.
class branch_shadow;
  logic [gsb_pkg::HISTORY_BITS-1:0] history;
  gsb_pkg::ctr_entry_t              counters [gsb_pkg::TABLE_DEPTH];
  gsb_pkg::tgt_entry_t              targets  [gsb_pkg::TABLE_DEPTH];
  branch_outlook_t                  pending_outlooks [$];
  int unsigned                      faults;

  function new();
    history = '0;
    faults  = 0;
    foreach (counters[i]) counters[i] = '0;
    foreach (targets[i]) targets[i] = '0;
  endfunction

  function void take_command(input logic [gsb_pkg::OP_W-1:0]      op,
                             input logic [gsb_pkg::ADDR_BITS-1:0] addr,
                             input logic                          taken,
                             input logic [gsb_pkg::ADDR_BITS-1:0] tgt);
    branch_outlook_t               want;
    logic [gsb_pkg::ADDR_BITS-1:0] ix;
    logic [1:0]                    ctr;
    want = '0;
    ix   = addr ^ gsb_pkg::ADDR_BITS'(history);
    case (op)
      gsb_pkg::OP_PREDICT: begin
        if (targets[addr].valid) begin
          want.hit    = 1'b1;
          want.target = targets[addr].target;
          if (!counters[ix].valid) begin
            counters[ix].valid = 1'b1;
            counters[ix].value = gsb_pkg::CTR_WEAK_TAKEN;
          end
          want.taken = (counters[ix].value >= gsb_pkg::CTR_WEAK_TAKEN);
        end
      end
      gsb_pkg::OP_UPDATE: begin
        ctr = counters[ix].valid ? counters[ix].value : gsb_pkg::CTR_MIN;
        if (taken) begin
          if (ctr != gsb_pkg::CTR_MAX) ctr = ctr + 2'd1;
        end else if (ctr != gsb_pkg::CTR_MIN) begin
          ctr = ctr - 2'd1;
        end
        counters[ix].valid = 1'b1;
        counters[ix].value = ctr;
        history = {history[gsb_pkg::HISTORY_BITS-2:0], taken};
      end
      gsb_pkg::OP_INSTALL: begin
        targets[addr].valid  = 1'b1;
        targets[addr].target = tgt;
      end
      default: begin
      end
    endcase
    pending_outlooks.push_back(want);
  endfunction

  function void match_result(input logic                          hit,
                             input logic                          taken,
                             input logic [gsb_pkg::ADDR_BITS-1:0] tgt);
    branch_outlook_t want;
    if (pending_outlooks.size() == 0) begin
      $display("%0t: result word with nothing outstanding: hit %0b taken %0b target %0d",
               $time, hit, taken, tgt);
      faults++;
      return;
    end
    want = pending_outlooks.pop_front();
    if (hit !== want.hit) begin
      $display("%0t: buffer_hit expected %0b actual %0b", $time, want.hit, hit);
      faults++;
    end
    if (taken !== want.taken) begin
      $display("%0t: predict_taken expected %0b actual %0b", $time, want.taken, taken);
      faults++;
    end
    if (tgt !== want.target) begin
      $display("%0t: predicted_target expected %0d actual %0d", $time, want.target, tgt);
      faults++;
    end
  endfunction
endclass

module tb_gshare_predictor_with_btb;
  timeunit 1ns;
  timeprecision 1ps;

  import gsb_pkg::*;

  // Code 3 is not a defined operation; the block must ignore it and still
  // return an all-zero result word.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // The block clears both tables entry by entry after reset, so the quiet
  // limit has to sit well above the length of that pass.
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned RANDOM_WORDS = 880;
  localparam int unsigned HOT_COUNT    = 16;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      in_operation = '0;
  logic [ADDR_BITS-1:0] in_branch_address = '0;
  logic                 in_outcome_taken = 1'b0;
  logic [ADDR_BITS-1:0] in_target_address = '0;
  logic                 out_valid;
  logic                 out_buffer_hit;
  logic                 out_predict_taken;
  logic [ADDR_BITS-1:0] out_predicted_target;

  branch_shadow         book;
  bit                   gaps_on = 1'b1;
  int unsigned          quiet_cycles = 0;
  logic [ADDR_BITS-1:0] hot_addr [HOT_COUNT];

  gshare_predictor_with_btb u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_operation         (in_operation),
    .in_branch_address    (in_branch_address),
    .in_outcome_taken     (in_outcome_taken),
    .in_target_address    (in_target_address),
    .out_valid            (out_valid),
    .out_buffer_hit       (out_buffer_hit),
    .out_predict_taken    (out_predict_taken),
    .out_predicted_target (out_predicted_target)
  );

  always #5 clk = ~clk;

  // Present one command word and hold it until the block takes it. The task
  // is always entered just after a rising edge. Idle cycles are drawn one at
  // a time, so a gap can land right after acceptance or in the middle of a
  // busy stretch. Each edge sees at most one assignment to start.
  task automatic send_word(input logic [OP_W-1:0]      op,
                           input logic [ADDR_BITS-1:0] addr,
                           input logic                 taken,
                           input logic [ADDR_BITS-1:0] tgt);
    while (gaps_on && $urandom_range(99) < 27) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start             <= 1'b1;
    in_operation      <= op;
    in_branch_address <= addr;
    in_outcome_taken  <= taken;
    in_target_address <= tgt;
    // busy is read before the edge's own updates land, so a low value here
    // means the word was taken at this very edge. An unknown busy is not
    // taken as acceptance.
    do @(posedge clk); while (busy !== 1'b0);
    book.take_command(op, addr, taken, tgt);
  endtask

  // Short directed opening: empty tables, both address extremes, the unseen
  // counter on predict and on update, saturation at the top, the unused
  // operation code and an install over an existing target.
  task automatic run_directed();
    send_word(OP_PREDICT, 10'd0, 1'b1, 10'd1023);   // miss on empty tables
    send_word(OP_UPDATE, 10'd5, 1'b0, 10'd0);       // unseen counter stays at 0
    send_word(OP_INSTALL, 10'd0, 1'b0, 10'd1023);
    send_word(OP_INSTALL, 10'd1023, 1'b1, 10'd0);
    send_word(OP_PREDICT, 10'd0, 1'b0, 10'd0);      // hit, unseen counter goes weak taken
    send_word(OP_PREDICT, 10'd1023, 1'b0, 10'd0);
    // Eight taken updates fill the history with ones; after that every taken
    // update at the same address lands on the same counter and drives it
    // into saturation.
    repeat (12) send_word(OP_UPDATE, 10'd0, 1'b1, 10'd0);
    send_word(OP_PREDICT, 10'd0, 1'b0, 10'd0);
    send_word(OP_UNUSED, 10'd1023, 1'b1, 10'd1023);
    send_word(OP_INSTALL, 10'd0, 1'b0, 10'd512);    // overwrite the old target
    send_word(OP_PREDICT, 10'd0, 1'b0, 10'd0);
    send_word(OP_UPDATE, 10'd1023, 1'b0, 10'd1023);
    send_word(OP_PREDICT, 10'd600, 1'b1, 10'd1);    // miss on a populated table
  endtask

  // Random part. Most addresses come from a small hot set so that installs,
  // predicts and updates keep meeting the same entries; the rest spread over
  // the whole address space. A stretch in the middle runs without gaps.
  task automatic run_random();
    logic [OP_W-1:0]      op;
    logic [ADDR_BITS-1:0] addr;
    int unsigned          roll;
    foreach (hot_addr[i]) hot_addr[i] = ADDR_BITS'($urandom);
    hot_addr[0] = '0;
    hot_addr[1] = '1;
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      gaps_on = !(n >= 300 && n < 450);
      roll = $urandom_range(99);
      if (roll < 45)      op = OP_PREDICT;
      else if (roll < 80) op = OP_UPDATE;
      else if (roll < 95) op = OP_INSTALL;
      else                op = OP_UNUSED;
      if ($urandom_range(99) < 65) addr = hot_addr[$urandom_range(HOT_COUNT-1)];
      else                         addr = ADDR_BITS'($urandom);
      send_word(op, addr, 1'($urandom), ADDR_BITS'($urandom));
    end
    gaps_on = 1'b1;
  endtask

  // The receiver cannot stall, so every strobed result word is checked at
  // the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      book.match_result(out_buffer_hit, out_predict_taken, out_predicted_target);
    end
  end

  // Watchdog: any edge that moves a command word or a result word counts as
  // progress. A long run of quiet edges means the block has hung or a result
  // went missing.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    book = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    start <= 1'b0;
    // Wait for every outstanding result, then a few more edges so that a
    // stray extra word would still be caught.
    while (book.pending_outlooks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.faults == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
